// ===== rtl/hps_pkg.sv =====
// Package: widths, register indexes, sequencer states and fixed-point constants.
package hps_pkg;

    localparam int DATA_WIDTH_DEF   = 32;
    localparam int NORMAL_WIDTH_DEF = 16;
    localparam int FRAC_BITS        = 24;
    localparam int CFG_IDX_WIDTH    = 3;
    localparam int CFG_DATA_WIDTH   = 32;
    localparam int INIT_VAR_WIDTH   = 31;
    localparam int RECIP_WIDTH      = 25;
    localparam int QSTEP_WIDTH      = 31;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_V0    = 3'd0,
        REG_X0    = 3'd1,
        REG_KDT   = 3'd2,
        REG_RECIP = 3'd3,
        REG_SD    = 3'd4,
        REG_RD1   = 3'd5,
        REG_RD2   = 3'd6,
        REG_Q     = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_G1,
        ST_G2,
        ST_GG,
        ST_Q,
        ST_SQ1,
        ST_T0,
        ST_SDS1,
        ST_SDS1G,
        ST_SDSD,
        ST_SDSDQ,
        ST_VN,
        ST_SQ2,
        ST_V12,
        ST_QV,
        ST_RS1,
        ST_RS1G,
        ST_S12,
        ST_SR2,
        ST_SR2G,
        ST_RSD,
        ST_RSDQ,
        ST_X,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/heston_path_step_top.sv =====
// Top level: Heston path step on one shared multiplier, adder and square-root unit.
//
//  channel  | direction | handshake            | payload
//  s_axis   | in        | tvalid/tready        | tdata: normal_first, normal_second; tuser: last_step
//  m_axis   | out       | tvalid/tready        | tdata: terminal_log_price, terminal_variance
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An item runs through the sequencer states and two square roots; the bit-serial square
// root and the single shared multiplier set how fast items pass. s_axis_tready is low
// while an item is in work. Reset clears the control state and loads the register
// defaults; a result waits in the output register until taken, and the next item is
// accepted meanwhile; a further result holds the sequencer in its last state until the
// register is free.
module heston_path_step_top
    import hps_pkg::*;
#(
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
    parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // normal_first [NW-1:0], normal_second [2NW-1:NW]
    input  logic [((2*NORMAL_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // last_step
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // terminal_log_price [31:0], terminal_variance [63:32]
    output logic [63:0]                   m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     cfg_data
);

    localparam int DW  = DATA_WIDTH;
    localparam int NW  = NORMAL_WIDTH;
    localparam int PW  = 2*DW;
    localparam int RW  = DW/2 + FRAC_BITS/2 + 1;
    localparam int RCW = $clog2(RW+1);
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    // Configuration registers
    logic [INIT_VAR_WIDTH-1:0] v0_reg;
    logic signed [31:0] x0_reg, kdt_reg, sd_reg, rd1_reg, rd2_reg;
    logic [RECIP_WIDTH-1:0] recip_reg;
    logic [QSTEP_WIDTH-1:0] qs_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= '0;
            x0_reg    <= '0;
            kdt_reg   <= '0;
            recip_reg <= RECIP_WIDTH'(1 << FRAC_BITS);
            sd_reg    <= '0;
            rd1_reg   <= '0;
            rd2_reg   <= '0;
            qs_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_V0:    v0_reg    <= cfg_data[INIT_VAR_WIDTH-1:0];
                REG_X0:    x0_reg    <= cfg_data;
                REG_KDT:   kdt_reg   <= cfg_data;
                REG_RECIP: recip_reg <= cfg_data[RECIP_WIDTH-1:0];
                REG_SD:    sd_reg    <= cfg_data;
                REG_RD1:   rd1_reg   <= cfg_data;
                REG_RD2:   rd2_reg   <= cfg_data;
                REG_Q:     qs_reg    <= cfg_data[QSTEP_WIDTH-1:0];
                default:   ;
            endcase
        end
    end

    // Fit a 64-bit signed register value into DW bits with saturation
    function automatic logic signed [DW-1:0] fit(input logic signed [63:0] a);
        if (a > 64'(signed'(DMAX)))
            fit = DMAX;
        else if (a < 64'(signed'(DMIN)))
            fit = DMIN;
        else
            fit = a[DW-1:0];
    endfunction

    // Shared saturating adder
    function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
            sadd = s[DW] ? DMIN : DMAX;
        else
            sadd = s[DW-1:0];
    endfunction

    // State
    state_t state_reg, state_next;
    logic signed [DW-1:0] v_reg, x_reg, g1_reg, g2_reg, q_reg, s1_reg, s2_reg;
    logic signed [DW-1:0] v1_reg, t_reg, vn_reg, dx_reg, acc_reg;
    logic open_reg, last_reg;
    logic [63:0] out_reg;
    logic out_valid_reg;

    // Shared multiplier operands and round shift
    logic signed [DW-1:0] ma, mb;
    logic [5:0] msh;
    logic signed [PW-1:0] prod;
    logic [PW-1:0] pmag, prnd;
    logic [PW:0] psum;
    logic [PW-1:0] pshift;
    logic pneg;
    logic signed [DW-1:0] mres;

    assign prod = PW'(ma) * PW'(mb);
    always_comb
    begin
        pneg   = prod[PW-1];
        pmag   = pneg ? PW'(-prod) : PW'(prod);
        prnd   = PW'(1) << (msh - 6'd1);
        psum   = {1'b0, pmag} + {1'b0, prnd};
        pshift = PW'(psum >> msh);
        if (pneg)
        begin
            if (pshift > PW'({1'b1, {(DW-1){1'b0}}}) || psum[PW])
                mres = DMIN;
            else
                mres = DW'(-pshift);
        end
        else
        begin
            if (pshift > PW'(DMAX) || psum[PW])
                mres = DMAX;
            else
                mres = pshift[DW-1:0];
        end
    end

    // Shared bit-serial square root: floor(sqrt(x * 2^24))
    logic [2*RW-1:0] rad_reg, rem_reg;
    logic [RW-1:0] root_reg;
    logic [RCW-1:0] rcnt_reg;
    logic sq_busy_reg, sq_start;
    logic signed [DW-1:0] sq_in;
    logic [RW+1:0] trial;
    logic [RW+1:0] remsh;

    always_comb
    begin
        remsh = {rem_reg[RW-1:0], rad_reg[2*RW-1:2*RW-2]};
        trial = {root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            rcnt_reg    <= '0;
        end
        else if (sq_start)
        begin
            sq_busy_reg <= 1'b1;
            rcnt_reg    <= RCW'(RW);
            rad_reg     <= (2*RW)'(sq_in[DW-1] ? '0 : sq_in) << FRAC_BITS;
            rem_reg     <= '0;
            root_reg    <= '0;
        end
        else if (sq_busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (remsh >= trial)
            begin
                rem_reg  <= (2*RW)'(remsh - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= (2*RW)'(remsh);
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
            rcnt_reg <= rcnt_reg - RCW'(1);
            if (rcnt_reg == RCW'(1))
                sq_busy_reg <= 1'b0;
        end
    end

    logic signed [DW-1:0] sq_out;
    assign sq_out = ({1'b0, root_reg} > (RW+1)'(DMAX)) ? DMAX : DW'(root_reg);

    logic s_fire;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    logic signed [DW-1:0] one_q;
    assign one_q = DW'(1 << FRAC_BITS);

    // Sequencer: next state and operand selection
    always_comb
    begin
        state_next = state_reg;
        ma = '0;
        mb = '0;
        msh = 6'(FRAC_BITS);
        sq_start = 1'b0;
        sq_in = '0;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) state_next = ST_G1;
            ST_G1:
            begin
                ma = g1_reg; mb = one_q; msh = 6'(NW-4);
                state_next = ST_G2;
            end
            ST_G2:
            begin
                ma = g2_reg; mb = one_q; msh = 6'(NW-4);
                state_next = ST_GG;
            end
            ST_GG:
            begin
                ma = g1_reg; mb = g1_reg;
                state_next = ST_Q;
            end
            ST_Q:
            begin
                sq_start = 1'b1; sq_in = v_reg;
                state_next = ST_SQ1;
            end
            ST_SQ1:   if (!sq_busy_reg) state_next = ST_T0;
            ST_T0:    state_next = ST_SDS1;
            ST_SDS1:
            begin
                ma = fit(64'(sd_reg)); mb = s1_reg;
                state_next = ST_SDS1G;
            end
            ST_SDS1G:
            begin
                ma = acc_reg; mb = g1_reg;
                state_next = ST_SDSD;
            end
            ST_SDSD:
            begin
                ma = fit(64'(sd_reg)); mb = fit(64'(sd_reg)); msh = 6'(FRAC_BITS+2);
                state_next = ST_SDSDQ;
            end
            ST_SDSDQ:
            begin
                ma = acc_reg; mb = q_reg;
                state_next = ST_VN;
            end
            ST_VN:
            begin
                ma = t_reg; mb = fit(64'(recip_reg));
                sq_start = 1'b1; sq_in = mres;
                state_next = ST_SQ2;
            end
            ST_SQ2:   if (!sq_busy_reg) state_next = ST_V12;
            ST_V12:   state_next = ST_QV;
            ST_QV:
            begin
                ma = fit(64'(qs_reg)); mb = v1_reg;
                state_next = ST_RS1;
            end
            ST_RS1:
            begin
                ma = fit(64'(rd1_reg)); mb = s1_reg;
                state_next = ST_RS1G;
            end
            ST_RS1G:
            begin
                ma = acc_reg; mb = g1_reg;
                state_next = ST_S12;
            end
            ST_S12:   state_next = ST_SR2;
            ST_SR2:
            begin
                ma = acc_reg; mb = fit(64'(rd2_reg)); msh = 6'(FRAC_BITS+1);
                state_next = ST_SR2G;
            end
            ST_SR2G:
            begin
                ma = acc_reg; mb = g2_reg;
                state_next = ST_RSD;
            end
            ST_RSD:
            begin
                ma = fit(64'(rd1_reg)); mb = fit(64'(sd_reg)); msh = 6'(FRAC_BITS+2);
                state_next = ST_RSDQ;
            end
            ST_RSDQ:
            begin
                ma = acc_reg; mb = q_reg;
                state_next = ST_X;
            end
            ST_X:     state_next = ST_OUT;
            ST_OUT:   if (!last_reg || !out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            v_reg         <= '0;
            x_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && last_reg && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        g1_reg   <= DW'(signed'(s_axis_tdata[NW-1:0]));
                        g2_reg   <= DW'(signed'(s_axis_tdata[2*NW-1:NW]));
                        last_reg <= s_axis_tuser;
                        if (!open_reg)
                        begin
                            v_reg    <= fit(64'(v0_reg));
                            x_reg    <= fit(64'(x0_reg));
                            open_reg <= 1'b1;
                        end
                    end
                end
                ST_G1:   g1_reg <= mres;
                ST_G2:   g2_reg <= mres;
                ST_GG:   q_reg  <= sadd(mres, -one_q);
                ST_Q:    v1_reg <= v_reg[DW-1] ? '0 : v_reg;
                ST_SQ1:  if (!sq_busy_reg) s1_reg <= sq_out;
                ST_T0:   t_reg  <= sadd(v_reg, fit(64'(kdt_reg)));
                ST_SDS1: acc_reg <= mres;
                ST_SDS1G: t_reg <= sadd(t_reg, mres);
                ST_SDSD: acc_reg <= mres;
                ST_SDSDQ: t_reg <= sadd(t_reg, mres);
                ST_VN:   vn_reg <= mres;
                ST_V12:
                begin
                    s2_reg <= sq_out;
                    v1_reg <= sadd(v1_reg, vn_reg[DW-1] ? '0 : vn_reg);
                end
                ST_QV:   dx_reg <= (mres == DMIN) ? DMAX : -mres;
                ST_RS1:  acc_reg <= mres;
                ST_RS1G:
                begin
                    dx_reg  <= sadd(dx_reg, mres);
                end
                ST_S12:  acc_reg <= sadd(s1_reg, s2_reg);
                ST_SR2:  acc_reg <= mres;
                ST_SR2G: dx_reg <= sadd(dx_reg, mres);
                ST_RSD:  acc_reg <= mres;
                ST_RSDQ: dx_reg <= sadd(dx_reg, mres);
                ST_X:
                begin
                    x_reg <= sadd(x_reg, dx_reg);
                    v_reg <= vn_reg;
                end
                ST_OUT:
                begin
                    if (last_reg && (!out_valid_reg || m_axis_tready))
                    begin
                        out_reg  <= {32'(vn_reg), 32'(x_reg)};
                        open_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
